>>> src/irt_pkg.sv
package irt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int ENTRY_W     = 2 * ID_W;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2
    } action_t;

    // RAM request from the controller: one write port, one read port
    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [ENTRY_W-1:0]   wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } mem_req_t;

endpackage

>>> src/irt_ram.sv
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/irt_ctrl.sv
module irt_ctrl
    import irt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          action,
    input  logic [ID_W-1:0]     ghost_id,
    input  logic [ID_W-1:0]     new_id,
    output logic                busy,
    output mem_req_t            mem_req,
    input  logic [ENTRY_W-1:0]  mem_rdata,
    output logic                done,
    output logic                found,
    output logic [ID_W-1:0]     mapped_id,
    output logic                status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [ID_W-1:0]     key_reg, key_next;
    logic                done_reg, done_next;
    logic                found_reg, found_next;
    logic [ID_W-1:0]     mapped_reg, mapped_next;
    logic                status_reg, status_next;

    logic [CNT_W-1:0]    cnt_dec;
    logic [ADDR_W-1:0]   idx_dec;
    logic [ID_W-1:0]     rd_old;
    logic [ID_W-1:0]     rd_new;

    assign cnt_dec = cnt_reg - CNT_W'(1);
    assign idx_dec = idx_reg - ADDR_W'(1);
    assign rd_old  = mem_rdata[ENTRY_W-1:ID_W];
    assign rd_new  = mem_rdata[ID_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        key_next      = key_reg;
        done_next     = 1'b0;
        found_next    = 1'b0;
        mapped_next   = '0;
        status_next   = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = cnt_reg[ADDR_W-1:0];
        mem_req.wdata = {ghost_id, new_id};
        mem_req.re    = 1'b0;
        mem_req.raddr = cnt_dec[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            cnt_next  = '0;
                            done_next = 1'b1;
                        end
                        ACT_INSERT:
                        begin
                            done_next = 1'b1;
                            if (cnt_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                mem_req.we = 1'b1;
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        ACT_LOOKUP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                // newest entry first
                                mem_req.re = 1'b1;
                                idx_next   = cnt_dec[ADDR_W-1:0];
                                key_next   = ghost_id;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // rdata holds entry idx_reg; fetch the next older one in parallel
                if (rd_old == key_reg)
                begin
                    done_next   = 1'b1;
                    found_next  = 1'b1;
                    mapped_next = rd_new;
                    state_next  = S_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_dec;
                    idx_next      = idx_dec;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        mapped_reg <= mapped_next;
    end

    assign busy      = (state_reg == S_SCAN);
    assign done      = done_reg;
    assign found     = found_reg;
    assign mapped_id = mapped_reg;
    assign status    = status_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg != '0))
        else $error("scan with empty table");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (CNT_W'(idx_reg) < cnt_reg))
        else $error("scan index beyond entry count");

    a_found_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (found_reg || status_reg) |-> done_reg)
        else $error("result flag without strobe");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg |-> !found_reg)
        else $error("full flag and hit together");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_req.we)
        else $error("table write during scan");

endmodule

>>> src/id_remap_table_top.sv
// Clear and insert: result strobe in the cycle after the transfer; busy stays low.
// Lookup: one entry scanned per cycle, newest first, out of the single table RAM
// read port, until the first hit or the oldest entry; the result strobe is
// registered. busy is high while scanning; a new transfer can start in the
// cycle the result is shown. Results cannot be stalled by the receiver.
// Reset (rst_n low, async) empties the table; RAM contents are not cleared.
module id_remap_table_top
    import irt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       action,
    input  logic [ID_W-1:0]  ghost_id,
    input  logic [ID_W-1:0]  new_id,
    output logic             done,
    output logic             found,
    output logic [ID_W-1:0]  mapped_id,
    output logic             status
);

    mem_req_t            mem_req;
    logic [ENTRY_W-1:0]  mem_rdata;

    irt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .ghost_id  (ghost_id),
        .new_id    (new_id),
        .busy      (busy),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .done      (done),
        .found     (found),
        .mapped_id (mapped_id),
        .status    (status)
    );

    irt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

endmodule
